### src/wsd_pkg.sv
// Package for the WebSocket frame deframer: parse phases, result types, constants.
// Used by the parser, the top level and the testbench.
package wsd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } wsd_phase_type;

   localparam logic [6:0] LEN_EXT16   = 7'd126;
   localparam logic [6:0] LEN_EXT64   = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] frame_opcode_out;
      logic       has_payload;
      logic       frame_end;
      logic       frame_was_masked;
   } wsd_result_type;

   typedef struct packed {
      logic           valid;
      wsd_result_type result;
   } wsd_step_type;

endpackage

### src/wsd_req_if.sv
// Byte stream channel into the deframer: valid, ready and one stream byte.
// Standalone; no package needed.
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

### src/wsd_rsp_if.sv
// Result channel out of the deframer: valid, ready and the result fields.
// Standalone; no package needed.
interface wsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [3:0] frame_opcode_out;
   logic       has_payload;
   logic       frame_end;
   logic       frame_was_masked;

   modport source (output valid, output data_byte, output frame_opcode_out,
                   output has_payload, output frame_end, output frame_was_masked,
                   input ready);
   modport sink (input valid, input data_byte, input frame_opcode_out,
                 input has_payload, input frame_end, input frame_was_masked,
                 output ready);
endinterface

### src/wsd_parser.sv
// Frame header parser and payload unmasker, one byte per accepted transaction.
// Depends on wsd_pkg.
module wsd_parser import wsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   stream_byte,
   output wsd_step_type step
);

   wsd_phase_type phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] rem_ff, rem_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  key_idx_ff, key_idx_in;

   logic [6:0]  len7;
   logic        len_is_ext;
   logic [63:0] rem_shift;
   logic        rem_shift_zero;
   logic        rem_zero;
   logic        rem_last;
   logic        ext_last;
   logic [7:0]  key_byte;

   assign len7           = stream_byte[6:0];
   assign len_is_ext     = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
   assign rem_shift      = {rem_ff[55:0], stream_byte};
   assign rem_shift_zero = (rem_shift == 64'd0);
   assign rem_zero       = (rem_ff == 64'd0);
   assign rem_last       = (rem_ff == 64'd1);
   assign ext_last       = (ext_left_ff == 4'd1);

   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR1: begin
               if (len_is_ext)           phase_in = PH_EXT;
               else if (stream_byte[7])  phase_in = PH_KEY;
               else if (len7 == 7'd0)    phase_in = PH_HDR0;
               else                      phase_in = PH_DATA;
            end
            PH_EXT: begin
               if (ext_last) begin
                  if (mask_ff)             phase_in = PH_KEY;
                  else if (rem_shift_zero) phase_in = PH_HDR0;
                  else                     phase_in = PH_DATA;
               end
            end
            PH_KEY: begin
               if (ext_last) phase_in = rem_zero ? PH_HDR0 : PH_DATA;
            end
            PH_DATA: begin
               if (rem_last) phase_in = PH_HDR0;
            end
            default: phase_in = PH_HDR1;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      opcode_in   = opcode_ff;
      mask_in     = mask_ff;
      rem_in      = rem_ff;
      ext_left_in = ext_left_ff;
      key_in      = key_ff;
      key_idx_in  = key_idx_ff;
      step        = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_HDR1: begin
               mask_in    = stream_byte[7];
               key_idx_in = 2'd0;
               if (len7 == LEN_EXT16) begin
                  rem_in      = 64'd0;
                  ext_left_in = EXT16_BYTES;
               end else if (len7 == LEN_EXT64) begin
                  rem_in      = 64'd0;
                  ext_left_in = EXT64_BYTES;
               end else begin
                  rem_in = {57'd0, len7};
                  if (stream_byte[7]) ext_left_in = KEY_BYTES;
                  else if (len7 == 7'd0) step.valid = 1'b1;
               end
            end
            PH_EXT: begin
               rem_in      = rem_shift;
               ext_left_in = ext_left_ff - 4'd1;
               key_idx_in  = 2'd0;
               if (ext_last) begin
                  if (mask_ff) ext_left_in = KEY_BYTES;
                  else if (rem_shift_zero) step.valid = 1'b1;
               end
            end
            PH_KEY: begin
               key_in      = {key_ff[23:0], stream_byte};
               ext_left_in = ext_left_ff - 4'd1;
               key_idx_in  = 2'd0;
               if (ext_last && rem_zero) step.valid = 1'b1;
            end
            PH_DATA: begin
               key_idx_in                = key_idx_ff + 2'd1;
               rem_in                    = rem_ff - 64'd1;
               step.valid                = 1'b1;
               step.result.data_byte     = stream_byte ^ key_byte;
               step.result.has_payload   = 1'b1;
               step.result.frame_end     = rem_last;
            end
            default: begin
               opcode_in   = stream_byte[3:0];
               mask_in     = 1'b0;
               rem_in      = 64'd0;
               ext_left_in = 4'd0;
               key_in      = 32'd0;
               key_idx_in  = 2'd0;
            end
         endcase
         if (step.valid && !step.result.has_payload) step.result.frame_end = 1'b1;
      end
      step.result.frame_opcode_out = opcode_ff;
      step.result.frame_was_masked = mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         opcode_ff   <= 4'd0;
         mask_ff     <= 1'b0;
         rem_ff      <= 64'd0;
         ext_left_ff <= 4'd0;
         key_ff      <= 32'd0;
         key_idx_ff  <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         opcode_ff   <= opcode_in;
         mask_ff     <= mask_in;
         rem_ff      <= rem_in;
         ext_left_ff <= ext_left_in;
         key_ff      <= key_in;
         key_idx_ff  <= key_idx_in;
      end
   end

endmodule

### src/websocket_frame_deframer_core.sv
// WebSocket frame deframer: one stream byte per transaction, one result register.
// A result shows in the result register in the cycle after its byte is taken.
// Throughput: one byte per cycle; the result register stalls input only while held.
// Reset: synchronous; parser returns to the first header byte, result register empties.
// Depends on wsd_pkg, wsd_req_if, wsd_rsp_if and wsd_parser.
module websocket_frame_deframer_core import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req,
   wsd_rsp_if.source  rsp
);

   wsd_step_type   step;
   logic           accept;
   logic           rsp_valid_ff, rsp_valid_in;
   wsd_result_type rsp_data_ff, rsp_data_in;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req.stream_byte),
      .step        (step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req.ready) begin
         rsp_valid_in = step.valid;
         if (step.valid) rsp_data_in = step.result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.data_byte        = rsp_data_ff.data_byte;
   assign rsp.frame_opcode_out = rsp_data_ff.frame_opcode_out;
   assign rsp.has_payload      = rsp_data_ff.has_payload;
   assign rsp.frame_end        = rsp_data_ff.frame_end;
   assign rsp.frame_was_masked = rsp_data_ff.frame_was_masked;

   a_no_take_when_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !req.ready)
      else $error("input taken while result held");

   a_header_only_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.has_payload |->
         rsp_data_ff.frame_end && (rsp_data_ff.data_byte == 8'd0))
      else $error("malformed header-only result");

   a_result_needs_take: assert property (@(posedge clock) disable iff (reset)
      !$past(accept) && !$past(reset) && $past(!rsp_valid_ff) |-> !rsp_valid_ff)
      else $error("result without transaction");

endmodule

### dv/websocket_frame_deframer_core_tb.sv
// Testbench for websocket_frame_deframer_core: drives framed byte streams, predicts every result.
// Depends on wsd_pkg, wsd_req_if, wsd_rsp_if and the deframer RTL.
`timescale 1ns / 1ps

class frame_scoreboard;
   wsd_pkg::wsd_phase_type   phase;
   logic [3:0]               opcode;
   logic                     masked;
   logic [63:0]              remaining;
   logic [3:0]               bytes_left;
   logic [31:0]              key;
   logic [1:0]               key_idx;
   wsd_pkg::wsd_result_type  expected_results[$];
   int unsigned              errors;

   function new();
      phase     = wsd_pkg::PH_HDR0;
      opcode    = '0;
      masked    = 1'b0;
      remaining = '0;
      bytes_left = '0;
      key       = '0;
      key_idx   = '0;
      errors    = 0;
   endfunction

   function void push_result(logic [7:0] data, logic has, logic last);
      wsd_pkg::wsd_result_type r;
      r.data_byte        = data;
      r.frame_opcode_out = opcode;
      r.has_payload      = has;
      r.frame_end        = last;
      r.frame_was_masked = masked;
      expected_results.insert(expected_results.size(), r);
   endfunction

   // Empty frames finish here with a header-only result; other frames move on to their payload.
   function void header_complete();
      key_idx = '0;
      if (remaining == 64'd0) begin
         push_result(8'h00, 1'b0, 1'b1);
         phase = wsd_pkg::PH_HDR0;
      end else begin
         phase = wsd_pkg::PH_DATA;
      end
   endfunction

   function void length_known();
      if (masked) begin
         bytes_left = wsd_pkg::KEY_BYTES;
         phase = wsd_pkg::PH_KEY;
      end else begin
         header_complete();
      end
   endfunction

   function void note_byte(logic [7:0] b);
      logic [7:0] kb;
      case (phase)
         wsd_pkg::PH_HDR1: begin
            masked = b[7];
            remaining = '0;
            if (b[6:0] == wsd_pkg::LEN_EXT16) begin
               bytes_left = wsd_pkg::EXT16_BYTES;
               phase = wsd_pkg::PH_EXT;
            end else if (b[6:0] == wsd_pkg::LEN_EXT64) begin
               bytes_left = wsd_pkg::EXT64_BYTES;
               phase = wsd_pkg::PH_EXT;
            end else begin
               remaining = {57'd0, b[6:0]};
               length_known();
            end
         end
         wsd_pkg::PH_EXT: begin
            remaining = {remaining[55:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0) length_known();
         end
         wsd_pkg::PH_KEY: begin
            key = {key[23:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0) header_complete();
         end
         wsd_pkg::PH_DATA: begin
            kb = key[{~key_idx, 3'b000} +: 8];
            key_idx = key_idx + 2'd1;
            remaining = remaining - 64'd1;
            push_result(b ^ kb, 1'b1, remaining == 64'd0);
            if (remaining == 64'd0) phase = wsd_pkg::PH_HDR0;
         end
         default: begin
            opcode = b[3:0];
            masked = 1'b0;
            remaining = '0;
            bytes_left = '0;
            key = '0;
            key_idx = '0;
            phase = wsd_pkg::PH_HDR1;
         end
      endcase
   endfunction

   function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         errors++;
      end
   endfunction

   function void check_result(wsd_pkg::wsd_result_type got);
      wsd_pkg::wsd_result_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result transaction: %p", got);
         errors++;
         return;
      end
      want = expected_results.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("frame_opcode_out", 8'(want.frame_opcode_out), 8'(got.frame_opcode_out));
      compare_field("has_payload", 8'(want.has_payload), 8'(got.has_payload));
      compare_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
      compare_field("frame_was_masked", 8'(want.frame_was_masked), 8'(got.frame_was_masked));
   endfunction
endclass

module websocket_frame_deframer_core_tb;
   import wsd_pkg::*;

   typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_form_type;

   localparam int unsigned STREAM_BYTES = 450;
   localparam int unsigned STALL_LIMIT  = 2000;

   logic        clock = 1'b0;
   logic        reset;
   logic        steady = 1'b0;
   int unsigned sent_count = 0;
   int unsigned quiet_cycles = 0;
   frame_scoreboard sb;

   wsd_req_if req ();
   wsd_rsp_if rsp ();

   websocket_frame_deframer_core uut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= steady || ($urandom_range(0, 99) >= 29);
      end
   end

   always @(posedge clock) begin
      wsd_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.data_byte, rsp.frame_opcode_out, rsp.has_payload, rsp.frame_end,
                rsp.frame_was_masked};
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.stream_byte <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_byte(b);
      sent_count++;
      steady = (sent_count >= 150) && (sent_count < 300);
   endtask

   task automatic send_frame(input logic [7:0] hdr0, input logic masked,
                             input len_form_type form, input logic [63:0] len,
                             input int unsigned payload_bytes);
      send_byte(hdr0);
      case (form)
         LEN_SHORT: begin
            send_byte({masked, len[6:0]});
         end
         LEN_16: begin
            send_byte({masked, LEN_EXT16});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            send_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
         end
      endcase
      if (masked) repeat (4) send_byte(8'($urandom_range(0, 255)));
      repeat (payload_bytes) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int unsigned pick;
      int unsigned len;
      sb = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.stream_byte = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty frames, unmasked and masked, then non-minimal and zero extended lengths
      send_frame(8'h00, 1'b0, LEN_SHORT, 64'd0, 0);
      send_frame(8'hFF, 1'b1, LEN_SHORT, 64'd0, 0);
      send_frame(8'h8A, 1'b1, LEN_16, 64'd2, 2);
      send_frame(8'h0F, 1'b0, LEN_64, 64'd0, 0);
      send_frame(8'h73, 1'b0, LEN_16, 64'd0, 0);

      while (sent_count < STREAM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_frame(8'($urandom_range(0, 255)), 1'($urandom), LEN_SHORT, 64'd125, 125);
         end else if (pick < 70) begin
            len = $urandom_range(0, 12);
            send_frame(8'($urandom_range(0, 255)), 1'($urandom), LEN_SHORT, 64'(len), len);
         end else if (pick < 85) begin
            len = $urandom_range(0, 40);
            send_frame(8'($urandom_range(0, 255)), 1'($urandom), LEN_16, 64'(len), len);
         end else begin
            len = $urandom_range(0, 40);
            send_frame(8'($urandom_range(0, 255)), 1'($urandom), LEN_64, 64'(len), len);
         end
      end

      // huge length with bit 63 set: the stream ends inside its payload
      send_frame(8'($urandom_range(0, 255)), 1'b1, LEN_64,
                 {1'b1, 63'($urandom) << 32 | 63'($urandom)}, 20);
      req.valid <= 1'b0;

      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
